@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/lgr_pkg.sv @@
// ---------------------------------------------------------------------------
// LED glow ramp package
// Types, codes and reset values shared by the ramp controller modules.
// ---------------------------------------------------------------------------
package lgr_pkg;

	typedef enum logic [1:0] {
		MODE_DARK = 2'd0,
		MODE_UP   = 2'd1,
		MODE_DOWN = 2'd2,
		MODE_HOLD = 2'd3
	} mode_t;

	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] CMD_UP     = 8'h01;
	localparam logic [7:0] CMD_DOWN   = 8'h02;
	localparam logic [7:0] CMD_DARK   = 8'h04;

	localparam logic [1:0] CFG_DUTY_TOP     = 2'd0;
	localparam logic [1:0] CFG_DUTY_STEP    = 2'd1;
	localparam logic [1:0] CFG_PERIOD_SCALE = 2'd2;

	localparam logic [11:0] DUTY_TOP_RST     = 12'd2000;
	localparam logic [11:0] DUTY_STEP_RST    = 12'd100;
	localparam logic [5:0]  PERIOD_SCALE_RST = 6'd10;
	localparam logic [11:0] DUTY_MAX         = 12'hFFF;

	typedef struct packed {
		logic [11:0] duty_top;
		logic [11:0] duty_step;
		logic [5:0]  period_scale;
	} cfg_t;

	typedef struct packed {
		logic [11:0] duty;
		mode_t       mode;
		logic        frame_done;
	} result_t;

	function automatic mode_t decode_command(logic [7:0] b);
		mode_t m;
		m = MODE_HOLD;
		if (b == CMD_UP)
			m = MODE_UP;
		else if (b == CMD_DOWN)
			m = MODE_DOWN;
		else if (b == CMD_DARK)
			m = MODE_DARK;
		return m;
	endfunction

endpackage

@@ sv/lgr_core.sv @@
// ---------------------------------------------------------------------------
// LED glow ramp core
// Frame parser and ramp state; computes the result of one item per cycle while en is high.
// ---------------------------------------------------------------------------
module lgr_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             func,
	input  logic [7:0]       rx_byte,
	input  lgr_pkg::cfg_t    cfg,
	output lgr_pkg::result_t res
);

	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_CMD  = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	phase_t         phase_q, phase_nxt;
	lgr_pkg::mode_t pend_q, pend_nxt;
	lgr_pkg::mode_t mode_q, mode_nxt;
	logic [13:0]    period_q, period_nxt;
	logic [13:0]    count_q, count_nxt;
	logic [11:0]    level_q, level_nxt;
	logic [11:0]    duty_q, duty_nxt;
	logic           frame_nxt;

	logic [13:0] prod;
	logic [13:0] count_inc;
	logic [12:0] sum;
	logic [11:0] diff;

	assign prod      = {6'd0, rx_byte} * {8'd0, cfg.period_scale};
	assign count_inc = count_q + 14'd1;
	assign sum       = {1'b0, level_q} + {1'b0, cfg.duty_step};
	assign diff      = level_q - cfg.duty_step;

	always_comb begin
		phase_nxt  = phase_q;
		pend_nxt   = pend_q;
		mode_nxt   = mode_q;
		period_nxt = period_q;
		count_nxt  = count_q;
		level_nxt  = level_q;
		duty_nxt   = duty_q;
		frame_nxt  = 1'b0;
		if (func) begin
			unique case (phase_q)
				PH_CMD: begin
					pend_nxt  = lgr_pkg::decode_command(rx_byte);
					phase_nxt = PH_DATA;
				end
				PH_DATA: begin
					period_nxt = prod;
					mode_nxt   = pend_q;
					if (pend_q == lgr_pkg::MODE_DARK)
						duty_nxt = 12'd0;
					phase_nxt  = PH_WAIT;
					frame_nxt  = 1'b1;
				end
				default: begin
					phase_nxt = (rx_byte == lgr_pkg::START_BYTE) ? PH_CMD : PH_WAIT;
				end
			endcase
		end else begin
			unique case (mode_q)
				lgr_pkg::MODE_DARK: duty_nxt = 12'd0;
				lgr_pkg::MODE_HOLD: ;
				default: begin
					if (count_inc <= period_q) begin
						count_nxt = count_inc;
					end else begin
						count_nxt = 14'd0;
						if (mode_q == lgr_pkg::MODE_UP) begin
							duty_nxt  = sum[12] ? lgr_pkg::DUTY_MAX : sum[11:0];
							level_nxt = (sum >= {1'b0, cfg.duty_top}) ? 12'd0 : sum[11:0];
						end else if (level_q <= cfg.duty_step) begin
							// Going down past zero saturates the output and reloads the top.
							duty_nxt  = 12'd0;
							level_nxt = cfg.duty_top;
						end else begin
							duty_nxt  = diff;
							level_nxt = diff;
						end
					end
				end
			endcase
		end
	end

	assign res.duty       = duty_nxt;
	assign res.mode       = mode_nxt;
	assign res.frame_done = frame_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			pend_q   <= lgr_pkg::MODE_DARK;
			mode_q   <= lgr_pkg::MODE_DARK;
			period_q <= 14'd0;
			count_q  <= 14'd0;
			level_q  <= 12'd0;
			duty_q   <= 12'd0;
		end else if (en) begin
			phase_q  <= phase_nxt;
			pend_q   <= pend_nxt;
			mode_q   <= mode_nxt;
			period_q <= period_nxt;
			count_q  <= count_nxt;
			level_q  <= level_nxt;
			duty_q   <= duty_nxt;
		end
	end

endmodule

@@ sv/led_glow_ramp_controller_top.sv @@
// ---------------------------------------------------------------------------
// LED glow ramp controller
// Byte-framed command parser and tick-driven duty ramp for an LED PWM.
// ---------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------
//  item    | item_valid / item_stall    | func, rx_byte
//  result  | res_valid / res_stall      | duty, mode, frame_done
//  config  | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// Each item yields one result, held first in the input register and then in the
// result register. One item is accepted per cycle while item_stall is low.
// The input register advances whenever the result register is empty or taken,
// so a stall on the result side backs up to item_stall in the same cycle.
// Reset clears the parser and ramp state and reloads the configuration defaults.
// Configuration writes are always ready and take effect in the next cycle.
`include "assert_macros.svh"

module led_glow_ramp_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        func,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [11:0] duty,
	output logic [1:0]  mode,
	output logic        frame_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	lgr_pkg::cfg_t    cfg_q;
	lgr_pkg::result_t res_c;

	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;
	logic       accept;
	logic       advance;

	logic             res_valid_q;
	lgr_pkg::result_t res_q;
	logic             res_dark;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_top     <= lgr_pkg::DUTY_TOP_RST;
			cfg_q.duty_step    <= lgr_pkg::DUTY_STEP_RST;
			cfg_q.period_scale <= lgr_pkg::PERIOD_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lgr_pkg::CFG_DUTY_TOP:     cfg_q.duty_top     <= cfg_data;
				lgr_pkg::CFG_DUTY_STEP:    cfg_q.duty_step    <= cfg_data;
				lgr_pkg::CFG_PERIOD_SCALE: cfg_q.period_scale <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign advance    = valid_s1 && (!res_valid_q || !res_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			byte_s1 <= rx_byte;
		end
	end

	lgr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.func    (func_s1),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.res     (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance)
			res_valid_q <= 1'b1;
		else if (!res_stall)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_c;
	end

	assign res_valid  = res_valid_q;
	assign duty       = res_q.duty;
	assign mode       = res_q.mode;
	assign frame_done = res_q.frame_done;

	assign res_dark = res_valid_q && (res_q.mode == lgr_pkg::MODE_DARK);

	`ASSERT_SAME(a_stall_needs_item, item_stall, valid_s1, "stall raised with no item held")
	`ASSERT_NEXT(a_advance_fills, advance, res_valid_q, "processed transaction not presented")
	`ASSERT_SAME(a_dark_is_zero, res_dark, res_q.duty == 12'd0, "dark result with nonzero duty")

endmodule

@@ dv/glow_ramp_checker.sv @@
// ---------------------------------------------------------------------------
// Glow ramp checker
// Watches the item, result and configuration channels of the ramp controller,
// keeps its own copy of the parser and ramp state, and compares every result
// transaction in order against the duty, mode and frame flag it predicts.
// ---------------------------------------------------------------------------
module glow_ramp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic        func,
	input  logic [7:0]  rx_byte,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic [11:0] duty,
	input  logic [1:0]  mode,
	input  logic        frame_done,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	typedef enum logic [1:0] {
		SEEK_START = 2'd0,
		WANT_CMD   = 2'd1,
		WANT_DATA  = 2'd2
	} frame_state_t;

	lgr_pkg::cfg_t    cfg;
	frame_state_t     frame_state;
	lgr_pkg::mode_t   armed_mode;
	lgr_pkg::mode_t   ramp_mode;
	logic [13:0]      hold_period;
	logic [13:0]      tick_count;
	logic [11:0]      level;
	logic [11:0]      duty_now;
	lgr_pkg::result_t expected_glow[$];
	int               errors = 0;

	function automatic lgr_pkg::mode_t command_mode(logic [7:0] b);
		case (b)
			lgr_pkg::CMD_UP:   return lgr_pkg::MODE_UP;
			lgr_pkg::CMD_DOWN: return lgr_pkg::MODE_DOWN;
			lgr_pkg::CMD_DARK: return lgr_pkg::MODE_DARK;
			default:           return lgr_pkg::MODE_HOLD;
		endcase
	endfunction

	// Advances the predicted state by one item and returns what the block should show.
	task automatic predict_glow(input logic is_byte, input logic [7:0] b,
			output lgr_pkg::result_t r);
		logic        done;
		logic [12:0] sum;
		done = 1'b0;
		if (is_byte) begin
			case (frame_state)
				WANT_CMD: begin
					armed_mode = command_mode(b);
					frame_state = WANT_DATA;
				end
				WANT_DATA: begin
					hold_period = 14'(b) * 14'(cfg.period_scale);
					ramp_mode = armed_mode;
					if (ramp_mode == lgr_pkg::MODE_DARK)
						duty_now = '0;
					frame_state = SEEK_START;
					done = 1'b1;
				end
				default: begin
					frame_state = (b == lgr_pkg::START_BYTE) ? WANT_CMD : SEEK_START;
				end
			endcase
		end else begin
			case (ramp_mode)
				lgr_pkg::MODE_DARK: duty_now = '0;
				lgr_pkg::MODE_HOLD: ;
				default: begin
					tick_count = tick_count + 14'd1;
					if (tick_count > hold_period) begin
						tick_count = '0;
						if (ramp_mode == lgr_pkg::MODE_UP) begin
							sum = {1'b0, level} + {1'b0, cfg.duty_step};
							duty_now = (sum > {1'b0, lgr_pkg::DUTY_MAX}) ?
								lgr_pkg::DUTY_MAX : sum[11:0];
							level = (sum >= {1'b0, cfg.duty_top}) ? 12'd0 : sum[11:0];
						end else if (level <= cfg.duty_step) begin
							// Going below zero clamps the output and reloads the top.
							duty_now = '0;
							level = cfg.duty_top;
						end else begin
							level = level - cfg.duty_step;
							duty_now = level;
						end
					end
				end
			endcase
		end
		r.duty = duty_now;
		r.mode = ramp_mode;
		r.frame_done = done;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lgr_pkg::result_t want;
		lgr_pkg::result_t got;
		if (!arst_n) begin
			cfg.duty_top = lgr_pkg::DUTY_TOP_RST;
			cfg.duty_step = lgr_pkg::DUTY_STEP_RST;
			cfg.period_scale = lgr_pkg::PERIOD_SCALE_RST;
			frame_state = SEEK_START;
			armed_mode = lgr_pkg::MODE_DARK;
			ramp_mode = lgr_pkg::MODE_DARK;
			hold_period = '0;
			tick_count = '0;
			level = '0;
			duty_now = '0;
			expected_glow.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				got.duty = duty;
				got.mode = lgr_pkg::mode_t'(mode);
				got.frame_done = frame_done;
				if (expected_glow.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("checker: unexpected result duty=%0d mode=%0d frame_done=%0d",
							duty, mode, frame_done);
				end else begin
					want = expected_glow.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("checker: mismatch exp duty/mode/done=%0d/%0d/%0d got %0d/%0d/%0d",
								want.duty, want.mode, want.frame_done,
								duty, mode, frame_done);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lgr_pkg::CFG_DUTY_TOP:     cfg.duty_top = cfg_data;
					lgr_pkg::CFG_DUTY_STEP:    cfg.duty_step = cfg_data;
					lgr_pkg::CFG_PERIOD_SCALE: cfg.period_scale = cfg_data[5:0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				predict_glow(func, rx_byte, want);
				expected_glow.push_back(want);
			end
			mismatches <= errors;
			outstanding <= expected_glow.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
// ---------------------------------------------------------------------------
// Glow ramp controller testbench
// Sends directed frames and ticks, then phases of random framed traffic under
// several register settings and idle and stall patterns; the checker judges every result.
// ---------------------------------------------------------------------------
module testbench;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic        func;
	logic [7:0]  rx_byte;
	logic        res_valid;
	logic        res_stall;
	logic [11:0] duty;
	logic [1:0]  mode;
	logic        frame_done;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;
	int          fails;
	int          outstanding;
	int          idle_pct = 0;
	int          stall_pct = 0;

	led_glow_ramp_controller_top uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .func(func), .rx_byte(rx_byte),
		.res_valid(res_valid), .res_stall(res_stall),
		.duty(duty), .mode(mode), .frame_done(frame_done),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	glow_ramp_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .func(func), .rx_byte(rx_byte),
		.res_valid(res_valid), .res_stall(res_stall),
		.duty(duty), .mode(mode), .frame_done(frame_done),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(fails), .outstanding(outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n)
			res_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		#2_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// Leaves cfg_valid high so that back-to-back writes need no extra edge.
	task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic send_item(input logic is_byte, input logic [7:0] b);
		if ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		item_valid <= 1'b1;
		func <= is_byte;
		rx_byte <= b;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic send_tick();
		send_item(1'b0, 8'($urandom));
	endtask

	task automatic send_frame(input logic [7:0] cmd, input logic [7:0] data);
		send_item(1'b1, lgr_pkg::START_BYTE);
		send_item(1'b1, cmd);
		send_item(1'b1, data);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly complete frames with short hold periods followed by tick bursts,
	// plus stray bytes and frames broken by interleaved ticks.
	task automatic random_traffic(input int count);
		int          n;
		int          pick;
		int          ticks;
		logic [7:0]  cmd;
		logic [7:0]  data;
		logic [7:0]  b;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				case ($urandom_range(5))
					0, 1: cmd = lgr_pkg::CMD_UP;
					2, 3: cmd = lgr_pkg::CMD_DOWN;
					4:    cmd = lgr_pkg::CMD_DARK;
					default: cmd = 8'($urandom);
				endcase
				data = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(2));
				send_frame(cmd, data);
				ticks = $urandom_range(24);
				repeat (ticks) send_tick();
				n += 3 + ticks;
			end else if (pick < 85) begin
				b = 8'($urandom);
				send_item(1'b1, b);
				n++;
			end else begin
				send_item(1'b1, lgr_pkg::START_BYTE);
				send_tick();
				send_item(1'b1, 8'($urandom));
				n += 3;
			end
		end
	endtask

	task automatic run_phase(input logic [11:0] top, input logic [11:0] step,
			input logic [5:0] scale, input int idle, input int stall, input int count);
		write_reg(lgr_pkg::CFG_DUTY_TOP, top);
		write_reg(lgr_pkg::CFG_DUTY_STEP, step);
		write_reg(lgr_pkg::CFG_PERIOD_SCALE, {6'd0, scale});
		cfg_valid <= 1'b0;
		idle_pct = idle;
		stall_pct = stall;
		random_traffic(count);
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		func <= 1'b0;
		rx_byte <= '0;
		res_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= lgr_pkg::CFG_DUTY_TOP;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset register values.
		send_tick();
		send_item(1'b1, 8'h00);
		send_item(1'b1, 8'h7F);
		send_frame(lgr_pkg::CMD_UP, 8'h00);
		repeat (3) send_tick();
		// A start byte inside a frame is taken as command and data.
		send_frame(lgr_pkg::START_BYTE, lgr_pkg::START_BYTE);
		send_tick();
		send_frame(lgr_pkg::CMD_DOWN, 8'h00);
		repeat (4) send_tick();
		send_frame(lgr_pkg::CMD_DARK, 8'h80);
		send_tick();
		// A tick in the middle of a frame leaves the parser where it was.
		send_item(1'b1, lgr_pkg::START_BYTE);
		send_tick();
		send_item(1'b1, 8'h05);
		send_item(1'b1, 8'h07);
		drain();

		run_phase(12'd4095, 12'd3000, 6'd1, 0, 0, 120);
		run_phase(12'd1, 12'd1, 6'd63, 83, 0, 120);
		run_phase(12'd0, 12'd0, 6'd0, 0, 83, 90);
		run_phase(12'd1500, 12'd4095, 6'd5, 8, 8, 120);
		run_phase(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
			6'($urandom_range(1, 63)), 83, 0, 50);
		run_phase(12'd2000, 12'd100, 6'd10, 8, 8, 50);

		if (fails == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
